[design/xrg_pkg.sv]
// shared constants and types for the xoshiro256** generator
package xrg_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned SEED_W = 32;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned IDX_W = 2;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
    localparam logic [WORD_W-1:0] SEED_OFFSET = 64'h0000_0000_0123_4567;
    localparam logic [WORD_W-1:0] STAR_MUL_A  = 64'd5;
    localparam logic [WORD_W-1:0] STAR_MUL_B  = 64'd9;

    localparam int unsigned XOR_SHIFT = 17;
    localparam int unsigned ROT_STATE = 45;
    localparam int unsigned ROT_STAR  = 7;
    localparam int unsigned MIX_SH_A  = 30;
    localparam int unsigned MIX_SH_B  = 27;
    localparam int unsigned MIX_SH_C  = 31;

    localparam logic KIND_RESEED = 1'b0;
    localparam logic KIND_DRAW   = 1'b1;

    typedef enum logic [1:0] {
        PH_LL,
        PH_HL,
        PH_LH
    } mul_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_ADD,
        ST_MIX_A,
        ST_MIX_B,
        ST_DRAW_M5,
        ST_DRAW_M9,
        ST_DRAW_PUT
    } xrg_state_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned amt);
        logic [WORD_W-1:0] r;
        r = (v << amt) | (v >> (WORD_W - amt));
        return r;
    endfunction

endpackage

[design/xrg_mul64.sv]
// 64x64 multiply modulo 2^64 on one shared 32x32 multiplier over three passes
module xrg_mul64
    import xrg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] op_a,
    input  logic [WORD_W-1:0] op_b,
    output logic              done,
    output logic [WORD_W-1:0] product
);

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    mul_phase_t        phase_reg;
    mul_phase_t        phase_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [HALF_W-1:0] mul_x;
    logic [HALF_W-1:0] mul_y;
    logic [WORD_W-1:0] mul_p;

    always_comb begin
        mul_x      = a_reg[HALF_W-1:0];
        mul_y      = b_reg[HALF_W-1:0];
        acc_next   = acc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_LL: begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[HALF_W-1:0];
            end
            PH_HL: begin
                mul_x = a_reg[WORD_W-1:HALF_W];
                mul_y = b_reg[HALF_W-1:0];
            end
            PH_LH: begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[WORD_W-1:HALF_W];
            end
            default: begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[HALF_W-1:0];
            end
        endcase
        mul_p = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
        if (start) begin
            busy_next  = 1'b1;
            phase_next = PH_LL;
        end else if (busy_reg) begin
            case (phase_reg)
                PH_LL: begin
                    acc_next   = mul_p;
                    phase_next = PH_HL;
                end
                PH_HL: begin
                    // cross terms only reach the upper half
                    acc_next   = {acc_reg[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0],
                                  acc_reg[HALF_W-1:0]};
                    phase_next = PH_LH;
                end
                PH_LH: begin
                    acc_next   = {acc_reg[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0],
                                  acc_reg[HALF_W-1:0]};
                    phase_next = PH_LL;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
                default: begin
                    phase_next = PH_LL;
                    busy_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_LL;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[design/xoshiro256ss_random_generator_core.sv]
// xoshiro256** generator top level: sequencer, state words and output register
//
// A draw word (kind 1) returns rotl(s1*5,7)*9 and steps the four 64-bit state
// words; a reseed word (kind 0) loads a splitmix64 counter with seed+0x1234567
// and fills the state words from four splitmix64 outputs, giving no result.
// Before the first reseed the state is all zero and draws return zero. Every
// 64-bit product runs through one shared 32x32 multiplier in three passes.
// A draw runs two products plus sequencing before the next possible accept, and
// its word then shows on m_valid from the output register. A reseed runs four
// splitmix64 steps of two products each, eight products in total. s_ready is
// high only while the sequencer is idle. A finished result waits in the output
// register and does not block the next input word, but a draw that finishes
// while that register is still full holds in its last step until the waiting
// word is taken.
module xoshiro256ss_random_generator_core
    import xrg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [SEED_W-1:0] s_seed,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_random_word
);

    xrg_state_t        state_reg;
    xrg_state_t        state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [WORD_W-1:0] cnt_reg;
    logic [WORD_W-1:0] cnt_next;
    logic [WORD_W-1:0] words_reg [NUM_WORDS];
    logic [WORD_W-1:0] words_next [NUM_WORDS];
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [WORD_W-1:0] m_random_word_reg;
    logic [WORD_W-1:0] m_random_word_next;

    logic              mul_start;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic              mul_done;
    logic [WORD_W-1:0] mul_prod;

    xrg_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb begin
        logic [WORD_W-1:0] mix_sum;
        logic [WORD_W-1:0] t_val;
        logic [WORD_W-1:0] n0;
        logic [WORD_W-1:0] n1;
        logic [WORD_W-1:0] n2;
        logic [WORD_W-1:0] n3;

        state_next         = state_reg;
        idx_next           = idx_reg;
        cnt_next           = cnt_reg;
        words_next         = words_reg;
        mul_start          = 1'b0;
        mul_a              = '0;
        mul_b              = '0;
        m_valid_next       = m_valid_reg && !m_ready;
        m_random_word_next = m_random_word_reg;

        mix_sum = cnt_reg + GOLDEN_STEP;

        // xor/shift/rotate state step
        t_val = words_reg[1] << XOR_SHIFT;
        n2    = words_reg[2] ^ words_reg[0];
        n3    = words_reg[3] ^ words_reg[1];
        n1    = words_reg[1] ^ n2;
        n0    = words_reg[0] ^ n3;
        n2    = n2 ^ t_val;
        n3    = rotl(n3, ROT_STATE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_RESEED) begin
                        cnt_next   = {{(WORD_W-SEED_W){1'b0}}, s_seed} + SEED_OFFSET;
                        idx_next   = '0;
                        state_next = ST_MIX_ADD;
                    end else begin
                        mul_start     = 1'b1;
                        mul_a         = words_reg[1];
                        mul_b         = STAR_MUL_A;
                        words_next[0] = n0;
                        words_next[1] = n1;
                        words_next[2] = n2;
                        words_next[3] = n3;
                        state_next    = ST_DRAW_M5;
                    end
                end
            end
            ST_MIX_ADD: begin
                cnt_next   = mix_sum;
                mul_start  = 1'b1;
                mul_a      = mix_sum ^ (mix_sum >> MIX_SH_A);
                mul_b      = MIX_MUL_A;
                state_next = ST_MIX_A;
            end
            ST_MIX_A: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod ^ (mul_prod >> MIX_SH_B);
                    mul_b      = MIX_MUL_B;
                    state_next = ST_MIX_B;
                end
            end
            ST_MIX_B: begin
                if (mul_done) begin
                    words_next[idx_reg] = mul_prod ^ (mul_prod >> MIX_SH_C);
                    if (idx_reg == IDX_W'(NUM_WORDS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_MIX_ADD;
                    end
                end
            end
            ST_DRAW_M5: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = rotl(mul_prod, ROT_STAR);
                    mul_b      = STAR_MUL_B;
                    state_next = ST_DRAW_M9;
                end
            end
            ST_DRAW_M9: begin
                if (mul_done) begin
                    state_next = ST_DRAW_PUT;
                end
            end
            ST_DRAW_PUT: begin
                // product stays in the multiplier until the output slot frees
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_random_word_next = mul_prod;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                words_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            words_reg   <= words_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_random_word_reg <= m_random_word_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_random_word = m_random_word_reg;

endmodule
